@@ rtl/plbcd_pkg.sv @@
`timescale 1ns / 1ps

package plbcd_pkg;

  localparam int ENTRIES     = 64;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int SLOT_W      = 6;
  localparam int BLOCK_BYTES = 512;
  localparam int POS_W       = 48;
  localparam int PIN_W       = 8;
  localparam int STAMP_W     = 64;

  typedef enum logic [1:0] {
    REQ_GET   = 2'd0,
    REQ_REL   = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_WB    = 2'd1,
    KIND_FETCH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISALIGN = 2'd1,
    ST_BUSY     = 2'd2
  } status_t;

  // which result the output register is loaded with
  typedef enum logic [3:0] {
    OUT_MISALIGN,
    OUT_GET_BUSY,
    OUT_NONE_OK,
    OUT_HIT,
    OUT_WB_VICTIM,
    OUT_FETCH,
    OUT_GET_DONE,
    OUT_REL,
    OUT_FL_PEND,
    OUT_FL_FINAL,
    OUT_FL_NONE
  } out_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_HIT,
    WR_FETCH,
    WR_REL,
    WR_FLCLR
  } wr_sel_t;

  typedef struct packed {
    logic               dirty;
    logic [PIN_W-1:0]   pins;
    logic [POS_W-1:0]   position;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic     req_load;
    logic     scan_start;
    logic     scan_run;
    logic     rewind;
    logic     rel_read;
    logic     out_load;
    out_sel_t out_sel;
    wr_sel_t  wr_sel;
    logic     pend_take;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic misaligned;
    logic ent_valid;
    logic ent_last;
    logic ent_flush_wb;
    logic hit_found;
    logic victim_found;
    logic victim_dirty;
    logic pend;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/plbcd_dp.sv @@
`timescale 1ns / 1ps

module plbcd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  plbcd_pkg::cmd_t                      cmd,
  output plbcd_pkg::stat_t                     stat,
  input  plbcd_pkg::req_t                      in_req,
  input  logic [plbcd_pkg::POS_W-1:0]          in_pos,
  input  logic [plbcd_pkg::SLOT_W-1:0]         in_slot,
  input  logic                                 in_dirty,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_kind,
  output logic [1:0]                           out_status,
  output logic [plbcd_pkg::SLOT_W-1:0]         out_slot,
  output logic [plbcd_pkg::POS_W-1:0]          out_pos,
  output logic                                 out_hit,
  output logic                                 out_last
);

  localparam int IW = plbcd_pkg::IDX_W;

  // latched request
  plbcd_pkg::req_t                  req_type;
  logic [plbcd_pkg::POS_W-1:0]      req_pos;
  logic [plbcd_pkg::SLOT_W-1:0]     req_slot;
  logic                             req_dirty;

  // directory storage; valid bits stand in for the reset of the array
  logic [plbcd_pkg::ENTRIES-1:0]    valid_bits;
  plbcd_pkg::entry_t                mem [plbcd_pkg::ENTRIES];
  plbcd_pkg::entry_t                rdata;
  logic                             rvld;

  logic [IW:0]                      rd_cnt;
  logic                             dvalid;
  logic [IW-1:0]                    proc_idx;

  logic                             hit_found;
  logic [IW-1:0]                    hit_idx;
  plbcd_pkg::entry_t                hit_ent;
  logic                             fi_found;
  logic [IW-1:0]                    fi_idx;
  logic                             lru_found;
  logic [IW-1:0]                    lru_idx;
  plbcd_pkg::entry_t                lru_ent;
  logic                             busy;
  logic                             pend;
  logic [IW-1:0]                    pend_idx;
  logic [plbcd_pkg::POS_W-1:0]      pend_pos;

  logic [plbcd_pkg::STAMP_W-1:0]    use_clock;

  plbcd_pkg::entry_t                ent;
  logic                             proc;
  logic                             issue;
  logic [IW-1:0]                    raddr;
  logic                             ent_unpinned;
  logic                             ent_hit;
  logic                             ent_flush_wb;
  logic                             ent_busy;
  logic [IW-1:0]                    evict_idx;
  logic                             rel_ok;
  logic [plbcd_pkg::PIN_W-1:0]      rel_pins;
  logic                             out_free;

  logic                             wr_en;
  logic [IW-1:0]                    wr_addr;
  plbcd_pkg::entry_t                wr_data;
  logic                             stamp_use;

  // an entry never written reads as all zero
  assign ent          = rvld ? rdata : '0;
  assign proc         = dvalid && !cmd.rewind;
  assign issue        = cmd.scan_run && (rd_cnt < (IW+1)'(plbcd_pkg::ENTRIES));
  assign raddr        = cmd.rel_read ? IW'(req_slot) : rd_cnt[IW-1:0];
  assign ent_unpinned = (ent.pins == '0);
  assign ent_hit      = rvld && (ent.position == req_pos);
  assign ent_flush_wb = rvld && ent.dirty && ent_unpinned;
  assign ent_busy     = rvld && ent.dirty && !ent_unpinned;
  assign evict_idx    = fi_found ? fi_idx : lru_idx;
  assign rel_ok       = rvld && !ent_unpinned;
  assign rel_pins     = ent.pins - plbcd_pkg::PIN_W'(1);
  assign out_free     = !out_valid || out_ready;

  always_comb begin
    stat.req          = req_type;
    stat.misaligned   = (req_pos % plbcd_pkg::POS_W'(plbcd_pkg::BLOCK_BYTES)) != '0;
    stat.ent_valid    = dvalid;
    stat.ent_last     = (proc_idx == IW'(plbcd_pkg::ENTRIES - 1));
    stat.ent_flush_wb = ent_flush_wb;
    stat.hit_found    = hit_found;
    stat.victim_found = fi_found || lru_found;
    stat.victim_dirty = !fi_found && lru_ent.dirty;
    stat.pend         = pend;
    stat.out_free     = out_free;
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = proc_idx;
    wr_data   = ent;
    stamp_use = 1'b0;
    case (cmd.wr_sel)
      plbcd_pkg::WR_HIT: begin
        wr_en     = 1'b1;
        wr_addr   = hit_idx;
        wr_data   = hit_ent;
        if (hit_ent.pins != '1) begin
          wr_data.pins = hit_ent.pins + plbcd_pkg::PIN_W'(1);
        end
        wr_data.stamp = use_clock;
        stamp_use     = 1'b1;
      end
      plbcd_pkg::WR_FETCH: begin
        wr_en            = 1'b1;
        wr_addr          = evict_idx;
        wr_data.dirty    = 1'b0;
        wr_data.pins     = plbcd_pkg::PIN_W'(1);
        wr_data.position = req_pos;
        wr_data.stamp    = use_clock;
        stamp_use        = 1'b1;
      end
      plbcd_pkg::WR_REL: begin
        wr_en        = rel_ok;
        wr_addr      = IW'(req_slot);
        wr_data.pins = rel_pins;
        wr_data.dirty = ent.dirty || req_dirty;
        // stamp refreshed only when the last pin goes
        if (rel_pins == '0) begin
          wr_data.stamp = use_clock;
          stamp_use     = rel_ok;
        end
      end
      plbcd_pkg::WR_FLCLR: begin
        wr_en         = 1'b1;
        wr_addr       = proc_idx;
        wr_data.dirty = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rvld       <= 1'b0;
      use_clock  <= '0;
      dvalid     <= 1'b0;
      rd_cnt     <= '0;
      out_valid  <= 1'b0;
      req_type   <= plbcd_pkg::REQ_NOP;
    end else begin
      rvld <= valid_bits[raddr];
      if (wr_en && (cmd.wr_sel == plbcd_pkg::WR_FETCH)) begin
        valid_bits[wr_addr] <= 1'b1;
      end
      if (stamp_use) begin
        use_clock <= use_clock + plbcd_pkg::STAMP_W'(1);
      end
      if (cmd.req_load) begin
        req_type <= in_req;
      end

      if (cmd.scan_start) begin
        rd_cnt <= '0;
        dvalid <= 1'b0;
      end else if (cmd.rewind) begin
        // replay from the entry that could not be taken
        rd_cnt <= {1'b0, proc_idx};
        dvalid <= 1'b0;
      end else if (issue) begin
        rd_cnt <= rd_cnt + (IW+1)'(1);
        dvalid <= 1'b1;
      end else begin
        dvalid <= 1'b0;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_pos   <= in_pos;
      req_slot  <= in_slot;
      req_dirty <= in_dirty;
    end
    if (!cmd.scan_start && !cmd.rewind && issue) begin
      proc_idx <= rd_cnt[IW-1:0];
    end
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      hit_found <= 1'b0;
      fi_found  <= 1'b0;
      lru_found <= 1'b0;
      busy      <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (proc) begin
        if (ent_hit && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (!rvld && !fi_found) begin
          fi_found <= 1'b1;
        end
        if (rvld && ent_unpinned && (!lru_found || (ent.stamp < lru_ent.stamp))) begin
          lru_found <= 1'b1;
        end
        if (ent_busy) begin
          busy <= 1'b1;
        end
      end
      if (cmd.pend_take) begin
        pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      if (ent_hit && !hit_found) begin
        hit_idx <= proc_idx;
        hit_ent <= ent;
      end
      if (!rvld && !fi_found) begin
        fi_idx <= proc_idx;
      end
      if (rvld && ent_unpinned && (!lru_found || (ent.stamp < lru_ent.stamp))) begin
        lru_idx <= proc_idx;
        lru_ent <= ent;
      end
    end
    if (cmd.pend_take) begin
      pend_idx <= proc_idx;
      pend_pos <= ent.position;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind   <= plbcd_pkg::KIND_DONE;
      out_status <= plbcd_pkg::ST_OK;
      out_slot   <= '0;
      out_pos    <= '0;
      out_hit    <= 1'b0;
      out_last   <= 1'b1;
      case (cmd.out_sel)
        plbcd_pkg::OUT_MISALIGN: begin
          out_status <= plbcd_pkg::ST_MISALIGN;
        end
        plbcd_pkg::OUT_GET_BUSY: begin
          out_status <= plbcd_pkg::ST_BUSY;
        end
        plbcd_pkg::OUT_HIT: begin
          out_slot <= plbcd_pkg::SLOT_W'(hit_idx);
          out_hit  <= 1'b1;
        end
        plbcd_pkg::OUT_WB_VICTIM: begin
          out_kind <= plbcd_pkg::KIND_WB;
          out_slot <= plbcd_pkg::SLOT_W'(evict_idx);
          out_pos  <= lru_ent.position;
          out_last <= 1'b0;
        end
        plbcd_pkg::OUT_FETCH: begin
          out_kind <= plbcd_pkg::KIND_FETCH;
          out_slot <= plbcd_pkg::SLOT_W'(evict_idx);
          out_pos  <= req_pos;
          out_last <= 1'b0;
        end
        plbcd_pkg::OUT_GET_DONE: begin
          out_slot <= plbcd_pkg::SLOT_W'(evict_idx);
        end
        plbcd_pkg::OUT_REL: begin
          out_slot <= req_slot;
        end
        plbcd_pkg::OUT_FL_PEND: begin
          out_kind <= plbcd_pkg::KIND_WB;
          out_slot <= plbcd_pkg::SLOT_W'(pend_idx);
          out_pos  <= pend_pos;
          out_last <= 1'b0;
        end
        plbcd_pkg::OUT_FL_FINAL: begin
          out_kind   <= plbcd_pkg::KIND_WB;
          out_slot   <= plbcd_pkg::SLOT_W'(pend_idx);
          out_pos    <= pend_pos;
          out_status <= busy ? plbcd_pkg::ST_BUSY : plbcd_pkg::ST_OK;
        end
        plbcd_pkg::OUT_FL_NONE: begin
          out_status <= busy ? plbcd_pkg::ST_BUSY : plbcd_pkg::ST_OK;
        end
        default: begin
          out_last <= 1'b1;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over one not yet transferred");

  a_fetch_victim: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_sel == plbcd_pkg::WR_FETCH) |-> (fi_found || lru_found))
    else $error("fetch without a victim");

  a_flclr_entry: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_sel == plbcd_pkg::WR_FLCLR) |-> (dvalid && ent_flush_wb))
    else $error("flush cleared an entry that is not dirty and unpinned");

  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    stamp_use |=> (use_clock == $past(use_clock) + plbcd_pkg::STAMP_W'(1)))
    else $error("use clock did not advance after a stamp write");
`endif

endmodule

@@ rtl/plbcd_ctrl.sv @@
`timescale 1ns / 1ps

module plbcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  plbcd_pkg::stat_t  stat,
  output plbcd_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RESP,
    S_GSCAN,
    S_GDEC,
    S_FETCH,
    S_GDONE,
    S_REL_UPD,
    S_FSCAN,
    S_FEND
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.out_sel    = plbcd_pkg::OUT_NONE_OK;
    cmd.wr_sel     = plbcd_pkg::WR_NONE;
    case (state)
      S_IDLE: begin
        cmd.req_load = in_valid;
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req)
          plbcd_pkg::REQ_GET: begin
            if (stat.misaligned) begin
              state_next = S_RESP;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_GSCAN;
            end
          end
          plbcd_pkg::REQ_REL: begin
            cmd.rel_read = 1'b1;
            state_next   = S_REL_UPD;
          end
          plbcd_pkg::REQ_FLUSH: begin
            cmd.scan_start = 1'b1;
            state_next     = S_FSCAN;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_RESP: begin
        cmd.out_sel = (stat.req == plbcd_pkg::REQ_GET) ? plbcd_pkg::OUT_MISALIGN
                                                        : plbcd_pkg::OUT_NONE_OK;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_GSCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.ent_valid && stat.ent_last) begin
          state_next = S_GDEC;
        end
      end
      S_GDEC: begin
        if (stat.hit_found) begin
          cmd.out_sel = plbcd_pkg::OUT_HIT;
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.wr_sel   = plbcd_pkg::WR_HIT;
            state_next   = S_IDLE;
          end
        end else if (!stat.victim_found) begin
          cmd.out_sel = plbcd_pkg::OUT_GET_BUSY;
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (stat.victim_dirty) begin
          cmd.out_sel = plbcd_pkg::OUT_WB_VICTIM;
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_FETCH;
          end
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.out_sel = plbcd_pkg::OUT_FETCH;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.wr_sel   = plbcd_pkg::WR_FETCH;
          state_next   = S_GDONE;
        end
      end
      S_GDONE: begin
        cmd.out_sel = plbcd_pkg::OUT_GET_DONE;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_REL_UPD: begin
        // keep the read address on the slot so the data holds while stalled
        cmd.rel_read = 1'b1;
        cmd.out_sel  = plbcd_pkg::OUT_REL;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.wr_sel   = plbcd_pkg::WR_REL;
          state_next   = S_IDLE;
        end
      end
      S_FSCAN: begin
        cmd.scan_run = 1'b1;
        cmd.out_sel  = plbcd_pkg::OUT_FL_PEND;
        if (stat.ent_valid) begin
          // one write-back is held back so the final one can carry last
          if (stat.ent_flush_wb && stat.pend && !stat.out_free) begin
            cmd.rewind   = 1'b1;
            cmd.scan_run = 1'b0;
          end else begin
            if (stat.ent_flush_wb) begin
              cmd.pend_take = 1'b1;
              cmd.wr_sel    = plbcd_pkg::WR_FLCLR;
              cmd.out_load  = stat.pend;
            end
            if (stat.ent_last) begin
              state_next = S_FEND;
            end
          end
        end
      end
      S_FEND: begin
        cmd.out_sel = stat.pend ? plbcd_pkg::OUT_FL_FINAL : plbcd_pkg::OUT_FL_NONE;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/pinned_lru_block_cache_directory_top.sv @@
`timescale 1ns / 1ps

// Channel   Group    Handshake                tuser       tdata / tlast
// request   s_axis   s_axis_tvalid/tready     req_type    block_pos, slot_index, mark_dirty
// result    m_axis   m_axis_tvalid/tready     kind        status, slot, storage_pos, was_hit; last
//
// One request at a time. A get passes a dispatch state, then reads the 64-entry directory one
// entry a cycle through its single read port, then decides and issues its results. A flush
// write-back that meets a stalled result side backs the scan up one entry and tries again.
// Reset (rst, synchronous) empties the directory at once through per-entry valid bits. The
// request side is ready only between requests.

module pinned_lru_block_cache_directory_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // block_pos[47:0], slot_index[53:48], mark_dirty[54]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // status[1:0], slot[7:2], storage_pos[55:8], was_hit[56]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);

  plbcd_pkg::cmd_t                  cmd;
  plbcd_pkg::stat_t                 stat;
  logic [1:0]                       out_status;
  logic [plbcd_pkg::SLOT_W-1:0]     out_slot;
  logic [plbcd_pkg::POS_W-1:0]      out_pos;
  logic                             out_hit;

  plbcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plbcd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (plbcd_pkg::req_t'(s_axis_tuser)),
    .in_pos     (s_axis_tdata[47:0]),
    .in_slot    (s_axis_tdata[53:48]),
    .in_dirty   (s_axis_tdata[54]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_pos    (out_pos),
    .out_hit    (out_hit),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, out_hit, out_pos, out_slot, out_status};

endmodule
